// ===== rtl/plsr_pkg.sv =====
// Package for the line span rasterizer: widths, field types and the run record
// passed from the walker to the command emitter. No dependencies.
package plsr_pkg;
	localparam int COORD_BITS = 10;
	localparam int ADDR_BITS = 16;
	localparam int ERR_BITS = 13;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [7:0] RESET_PITCH = 8'd80;
	localparam logic [15:0] RIGHT_MASK_BASE = 16'hff80;
	localparam logic [7:0] POINT_MASK_BASE = 8'h80;
	localparam logic [7:0] FULL_MASK = 8'hff;
	localparam logic [9:0] COUNT_MAX = 10'd1023;
	localparam logic KIND_START = 1'b0;
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_FILL = 1'b1;
	localparam logic [1:0] CFG_PITCH = 2'd0;
	localparam logic [1:0] CFG_OP = 2'd1;

	typedef struct packed {
		logic kind;
		logic [9:0] x_start;
		logic [9:0] y_start;
		logic [9:0] x_end;
		logic [9:0] y_end;
		logic [3:0] pen_color;
	} in_word_t;

	typedef struct packed {
		logic command_kind;
		logic [7:0] bit_mask;
		logic [15:0] byte_address;
		logic [7:0] address_step;
		logic [9:0] byte_count;
		logic [3:0] write_color;
		logic [1:0] write_op;
		logic run_last;
		logic line_done;
	} out_word_t;

	typedef struct packed {
		logic steep;
		logic [COORD_BITS-1:0] minor;
		logic [COORD_BITS-1:0] lo;
		logic [COORD_BITS-1:0] hi;
		logic [3:0] color;
		logic done;
	} run_t;
endpackage

// ===== rtl/plsr_if.sv =====
// Valid/ready channel interface carrying one word of the given type.
// The word type T is a parameter, so the interface does not depend on plsr_pkg.
interface plsr_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/planar_line_span_rasterizer_top.sv =====
// Top level of the line span rasterizer: configuration registers, walker and
// command emitter. Depends on plsr_pkg, plsr_if, plsr_walk and plsr_emit.
//
// Input words arrive on in_ch; kind 0 loads a line and gives no command,
// kind 1 emits the commands of the next run (one to three words on out_ch,
// the last marked run_last, and line_done at the end of the line). A step
// word is accepted in IDLE, walked pixel by pixel in WALK and handed over
// in PUSH, so the walker takes no new word until its run is handed over;
// the emitter turns out one command per cycle while out_ready is high, from
// a two entry queue, overlapping the next walk. When the receiver stalls the
// output word holds, the queue fills, and then the walker and input stall.
// Reset clears all control state, sets row pitch to 80 and the op to replace;
// the block is ready in the first cycle after reset. Configuration writes
// through cfg_we, cfg_index and cfg_data take effect at once; the user must
// make them only while the block is idle, which the block does not enforce.
module planar_line_span_rasterizer_top import plsr_pkg::*; (
	input logic clk,
	input logic arst_n,
	plsr_if.sink in_ch,
	plsr_if.source out_ch,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [7:0] cfg_data
);
	logic [7:0] pitch_q;
	logic [1:0] op_q;
	logic run_valid, run_ready;
	run_t run_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= RESET_PITCH;
			op_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PITCH: pitch_q <= cfg_data;
				CFG_OP: op_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	plsr_walk u_walk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.run_valid(run_valid), .run_ready(run_ready), .run_data(run_data)
	);

	plsr_emit u_emit (
		.clk(clk), .arst_n(arst_n),
		.run_valid(run_valid), .run_ready(run_ready), .run_data(run_data),
		.pitch(pitch_q), .op(op_q),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
	);
endmodule

// ===== rtl/plsr_walk.sv =====
// Front part: latches lines and walks the error term one pixel per cycle,
// pushing one run record per step word of an active line. Depends on plsr_pkg.
module plsr_walk import plsr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_word_t in_data,
	output logic run_valid,
	input logic run_ready,
	output run_t run_data
);
	typedef enum logic [1:0] {IDLE, WALK, PUSH} st_t;
	st_t st_q;
	logic signed [COORD_BITS+1:0] major_q, minor_q, run_begin_q, cur_q, runminor_q;
	logic signed [ERR_BITS-1:0] err_q;
	logic [COORD_BITS:0] majd_q, mind_q, left_q;
	logic [1:0] dir_q;
	logic steep_q, active_q;
	logic [3:0] color_q;
	logic signed [COORD_BITS+1:0] dx, dy, adx, ady;
	logic steep_n, brk;
	logic [COORD_BITS:0] left_n;

	always_comb begin
		dx = $signed({2'b0, in_data.x_end}) - $signed({2'b0, in_data.x_start});
		dy = $signed({2'b0, in_data.y_end}) - $signed({2'b0, in_data.y_start});
		adx = dx[COORD_BITS+1] ? -dx : dx;
		ady = dy[COORD_BITS+1] ? -dy : dy;
		steep_n = (dx == '0) || (adx < ady);
		left_n = left_q - 1'b1;
		brk = (err_q > 0) || (left_n == '0);
	end

	assign in_ready = (st_q == IDLE);
	assign run_valid = (st_q == PUSH);

	always_comb begin
		run_data.steep = steep_q;
		run_data.minor = runminor_q[COORD_BITS-1:0];
		run_data.color = color_q;
		run_data.done = (left_q == '0);
		if ((!steep_q && run_begin_q > cur_q) || (steep_q && run_begin_q > cur_q)) begin
			run_data.lo = cur_q[COORD_BITS-1:0];
			run_data.hi = run_begin_q[COORD_BITS-1:0];
		end else begin
			run_data.lo = run_begin_q[COORD_BITS-1:0];
			run_data.hi = cur_q[COORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			active_q <= 1'b0;
			left_q <= '0;
		end else begin
			case (st_q)
				IDLE: begin
					if (in_valid) begin
						if (in_data.kind == KIND_START) begin
							steep_q <= steep_n;
							color_q <= in_data.pen_color;
							active_q <= 1'b1;
							if (steep_n) begin
								major_q <= {2'b0, in_data.y_start};
								run_begin_q <= {2'b0, in_data.y_start};
								minor_q <= {2'b0, in_data.x_start};
								majd_q <= ady[COORD_BITS:0];
								mind_q <= adx[COORD_BITS:0];
								left_q <= ady[COORD_BITS:0] + 1'b1;
								dir_q <= {dx[COORD_BITS+1], dy[COORD_BITS+1]};
								err_q <= ERR_BITS'(2 * adx - ady);
							end else begin
								major_q <= {2'b0, in_data.x_start};
								run_begin_q <= {2'b0, in_data.x_start};
								minor_q <= {2'b0, in_data.y_start};
								majd_q <= adx[COORD_BITS:0];
								mind_q <= ady[COORD_BITS:0];
								left_q <= adx[COORD_BITS:0] + 1'b1;
								dir_q <= {dy[COORD_BITS+1], dx[COORD_BITS+1]};
								err_q <= ERR_BITS'(2 * ady - adx);
							end
						end else if (!active_q || left_q == '0) begin
							active_q <= 1'b0;
						end else begin
							st_q <= WALK;
						end
					end
				end
				WALK: begin
					cur_q <= major_q;
					runminor_q <= minor_q;
					left_q <= left_n;
					if (err_q > 0) begin
						err_q <= err_q + ERR_BITS'({mind_q, 1'b0}) - ERR_BITS'({majd_q, 1'b0});
						minor_q <= dir_q[1] ? minor_q - 1'b1 : minor_q + 1'b1;
					end else begin
						err_q <= err_q + ERR_BITS'({mind_q, 1'b0});
					end
					if (left_n != '0)
						major_q <= dir_q[0] ? major_q - 1'b1 : major_q + 1'b1;
					if (brk)
						st_q <= PUSH;
				end
				PUSH: begin
					if (run_ready) begin
						run_begin_q <= major_q;
						if (left_q == '0)
							active_q <= 1'b0;
						st_q <= IDLE;
					end
				end
				default: st_q <= IDLE;
			endcase
		end
	end

	property p_walk_progress;
		@(posedge clk) disable iff (!arst_n) (st_q == WALK) |=> (left_q != $past(left_q));
	endproperty
	a_walk_progress: assert property (p_walk_progress) else $error("walk stalled");
	a_push_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == PUSH && !run_ready) |=> (st_q == PUSH)) else $error("run dropped");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != IDLE) |-> !in_ready) else $error("accept while busy");
endmodule

// ===== rtl/plsr_emit.sv =====
// Back part: queues run records and expands each into one to three frame
// buffer commands, with a registered output word. Depends on plsr_pkg.
module plsr_emit import plsr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic run_valid,
	output logic run_ready,
	input run_t run_data,
	input logic [7:0] pitch,
	input logic [1:0] op,
	output logic out_valid,
	input logic out_ready,
	output out_word_t out_data
);
	run_t q_mem [QUEUE_DEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic [1:0] idx_q;
	run_t r;
	logic [COORD_BITS-1:0] xa, xb;
	logic [COORD_BITS-3:0] span;
	logic [COORD_BITS+7:0] prod;
	logic [ADDR_BITS-1:0] mul_y, base;
	logic [7:0] lmask, rmask;
	logic [10:0] vcount;
	out_word_t cmd;
	logic last_cmd, load, pop, push;

	assign run_ready = (cnt_q != 2'd2);
	assign push = run_valid && run_ready;
	assign r = q_mem[rp_q];
	assign load = (cnt_q != '0) && (!out_valid || out_ready);

	always_comb begin
		xa = r.steep ? r.minor : r.lo;
		xb = r.hi;
		prod = {{COORD_BITS{1'b0}}, pitch} * {8'b0, (r.steep ? r.lo : r.minor)};
		mul_y = prod[ADDR_BITS-1:0];
		base = mul_y + ADDR_BITS'(xa[COORD_BITS-1:3]);
		lmask = FULL_MASK >> xa[2:0];
		rmask = 8'(RIGHT_MASK_BASE >> xb[2:0]);
		span = xb[COORD_BITS-1:3] - xa[COORD_BITS-1:3];
		vcount = {1'b0, r.hi} - {1'b0, r.lo} + 11'd1;
		cmd = '0;
		cmd.write_color = r.color;
		cmd.write_op = op;
		cmd.byte_count = 10'd1;
		last_cmd = 1'b1;
		if (r.steep) begin
			cmd.command_kind = CMD_FILL;
			cmd.bit_mask = POINT_MASK_BASE >> xa[2:0];
			cmd.byte_address = base;
			cmd.address_step = pitch;
			cmd.byte_count = (vcount > 11'(COUNT_MAX)) ? COUNT_MAX : vcount[9:0];
		end else if (span == '0) begin
			cmd.command_kind = CMD_WRITE;
			cmd.bit_mask = lmask & rmask;
			cmd.byte_address = base;
		end else if (idx_q == 2'd0) begin
			cmd.command_kind = CMD_WRITE;
			cmd.bit_mask = lmask;
			cmd.byte_address = base;
			last_cmd = 1'b0;
		end else if (idx_q == 2'd1 && span > 1) begin
			cmd.command_kind = CMD_FILL;
			cmd.bit_mask = FULL_MASK;
			cmd.byte_address = base + 1'b1;
			cmd.address_step = 8'd1;
			cmd.byte_count = 10'(span - 1'b1);
			last_cmd = 1'b0;
		end else begin
			cmd.command_kind = CMD_WRITE;
			cmd.bit_mask = rmask;
			cmd.byte_address = base + ADDR_BITS'(span);
		end
		cmd.run_last = last_cmd;
		cmd.line_done = last_cmd && r.done;
		pop = load && last_cmd;
	end

	always_ff @(posedge clk) begin
		if (push)
			q_mem[wp_q] <= run_data;
		if (load)
			out_data <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			if (load)
				idx_q <= last_cmd ? 2'd0 : idx_q + 2'd1;
			if (load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue overflow");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_data)) else $error("output changed");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n) idx_q != 2'd3)
		else $error("bad command index");
endmodule
